// ===== rtl/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cram_pkg
// Shared types, constants and sequencing tables for the single-register
// I2C master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int DIVIDER_BITS_DEF = 16;
  localparam int HALF_W           = 16;
  localparam int DEV_W            = 7;
  localparam int BYTE_W           = 8;
  localparam int IN_TDATA_W       = 24;
  localparam int OUT_TDATA_W      = 16;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic CFG_DEVICE_ADDRESS    = 1'b0;
  localparam logic CFG_HALF_PERIOD_TICKS = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef enum logic [2:0] {
    SEG_START,
    SEG_ADDRW,
    SEG_REG,
    SEG_DATA,
    SEG_ADDRR,
    SEG_RBYTE,
    SEG_STOP
  } seg_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;
  } item_t;

  // packed so that scl_out sits in the lowest bit
  typedef struct packed {
    logic              ack_missing;
    logic [BYTE_W-1:0] read_data;
    logic              done_res;
    logic              busy_res;
    logic              sda_out;
    logic              scl_out;
  } result_t;

  function automatic seg_t plan_kind(input logic rd, input logic [2:0] idx);
    seg_t k;
    k = SEG_STOP;
    if (rd) begin
      case (idx)
        3'd0:    k = SEG_START;
        3'd1:    k = SEG_ADDRW;
        3'd2:    k = SEG_REG;
        3'd3:    k = SEG_START;
        3'd4:    k = SEG_ADDRR;
        3'd5:    k = SEG_RBYTE;
        default: k = SEG_STOP;
      endcase
    end else begin
      case (idx)
        3'd0:    k = SEG_START;
        3'd1:    k = SEG_ADDRW;
        3'd2:    k = SEG_REG;
        3'd3:    k = SEG_DATA;
        default: k = SEG_STOP;
      endcase
    end
    return k;
  endfunction

  function automatic logic [2:0] plan_last(input logic rd);
    return rd ? 3'd6 : 3'd4;
  endfunction

  function automatic logic [4:0] seg_last(input seg_t k);
    logic [4:0] l;
    case (k)
      SEG_START: l = 5'd2;
      SEG_STOP:  l = 5'd2;
      SEG_RBYTE: l = 5'd17;
      default:   l = 5'd18;
    endcase
    return l;
  endfunction

endpackage

// ===== rtl/i2cram_front.sv =====
// ----------------------------------------------------------------------------
// i2cram_front
// Accepts input transactions, decodes the command and holds items in a
// two-entry queue ahead of the bus engine.
// ----------------------------------------------------------------------------
module i2cram_front
  import i2cram_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                  q_valid,
  input  logic                  q_ready,
  output item_t                 q_item
);

  item_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      in_item;

  always_comb begin
    case (s_axis_tdata[1:0])
      CMD_READ:  in_item.op = OP_READ;
      CMD_WRITE: in_item.op = OP_WRITE;
      default:   in_item.op = OP_NONE;
    endcase
    in_item.reg_addr   = s_axis_tdata[9:2];
    in_item.write_data = s_axis_tdata[17:10];
    in_item.sda_in     = s_axis_tdata[18];
  end

  assign s_axis_tready = (count != 2'd2);
  assign q_valid       = (count != 2'd0);
  assign q_item        = q_mem[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/i2cram_engine.sv =====
// ----------------------------------------------------------------------------
// i2cram_engine
// Bus sequencer: one divider tick per item, walks the segment plan of a
// read or write transaction and registers the line levels and status.
// ----------------------------------------------------------------------------
module i2cram_engine
  import i2cram_pkg::*;
#(
  parameter int DIVIDER_BITS = DIVIDER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  item_t             q_item,
  input  logic [DEV_W-1:0]  device_address,
  input  logic [HALF_W-1:0] half_period_ticks,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int CMP_W = (DIVIDER_BITS > HALF_W) ? DIVIDER_BITS : HALF_W;

  logic                    active,     active_next;
  logic                    is_read,    is_read_next;
  logic [2:0]              seg,        seg_next;
  logic [4:0]              pos,        pos_next;
  logic [DIVIDER_BITS-1:0] div,        div_next;
  logic [BYTE_W-1:0]       shift_byte, shift_byte_next;
  logic [BYTE_W-1:0]       saved_reg,  saved_reg_next;
  logic [BYTE_W-1:0]       saved_data, saved_data_next;
  logic [BYTE_W-1:0]       received,   received_next;
  logic                    nack,       nack_next;
  logic                    scl,        scl_next;
  logic                    sda,        sda_next;

  logic                    step;
  logic                    busy;
  logic                    done;
  logic                    sample;
  seg_t                    kind;
  logic [BYTE_W-1:0]       tx_byte;
  logic [DIVIDER_BITS-1:0] div_inc;
  logic [CMP_W-1:0]        half_w;
  logic [CMP_W-1:0]        max_w;
  logic [CMP_W-1:0]        eff_w;

  assign q_ready = !res_valid || res_ready;
  assign step    = q_valid && q_ready;

  always_comb begin
    half_w = CMP_W'(half_period_ticks);
    max_w  = CMP_W'({DIVIDER_BITS{1'b1}});
    eff_w  = (half_w > max_w) ? max_w : half_w;
    if (eff_w == '0) begin
      eff_w = CMP_W'(1);
    end
  end

  always_comb begin
    active_next     = active;
    is_read_next    = is_read;
    seg_next        = seg;
    pos_next        = pos;
    div_next        = div;
    shift_byte_next = shift_byte;
    saved_reg_next  = saved_reg;
    saved_data_next = saved_data;
    received_next   = received;
    nack_next       = nack;
    scl_next        = scl;
    sda_next        = sda;
    busy            = 1'b0;
    done            = 1'b0;
    sample          = 1'b0;
    kind            = SEG_START;
    tx_byte         = '0;
    div_inc         = '0;

    if (step) begin
      if (!active && q_item.op != OP_NONE) begin
        active_next     = 1'b1;
        is_read_next    = (q_item.op == OP_READ);
        saved_reg_next  = q_item.reg_addr;
        saved_data_next = q_item.write_data;
        nack_next       = 1'b0;
        shift_byte_next = '0;
        div_next        = '0;
        seg_next        = 3'd0;
        pos_next        = 5'd0;
      end

      if (active_next) begin
        busy = 1'b1;
        kind = plan_kind(is_read_next, seg_next);
        case (kind)
          SEG_ADDRW: tx_byte = {device_address, 1'b0};
          SEG_ADDRR: tx_byte = {device_address, 1'b1};
          SEG_REG:   tx_byte = saved_reg_next;
          default:   tx_byte = saved_data_next;
        endcase

        case (kind)
          SEG_START: begin
            scl_next = (pos_next < 5'd2);
            sda_next = (pos_next == 5'd0);
          end
          SEG_STOP: begin
            scl_next = (pos_next != 5'd0);
            sda_next = (pos_next == 5'd2);
          end
          SEG_RBYTE: begin
            scl_next = pos_next[0];
            sda_next = 1'b1;
            sample   = !pos_next[4] && pos_next[0];
          end
          default: begin
            if (!pos_next[4]) begin
              scl_next = pos_next[0];
              sda_next = tx_byte[~pos_next[3:1]];
            end else begin
              scl_next = (pos_next == 5'd17);
              sda_next = 1'b1;
              sample   = (pos_next == 5'd17);
            end
          end
        endcase

        div_inc = div_next + DIVIDER_BITS'(1);
        if (CMP_W'(div_inc) >= eff_w) begin
          div_next = '0;
          if (sample) begin
            if (kind == SEG_RBYTE) begin
              shift_byte_next = {shift_byte_next[BYTE_W-2:0], q_item.sda_in};
              if (pos_next == 5'd15) begin
                received_next = shift_byte_next;
              end
            end else if (q_item.sda_in) begin
              nack_next = 1'b1;
            end
          end
          if (pos_next == seg_last(kind)) begin
            pos_next = 5'd0;
            if (seg_next == plan_last(is_read_next)) begin
              seg_next    = 3'd0;
              active_next = 1'b0;
              done        = 1'b1;
            end else begin
              seg_next = seg_next + 3'd1;
            end
          end else begin
            pos_next = pos_next + 5'd1;
          end
        end else begin
          div_next = div_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      is_read    <= 1'b0;
      seg        <= 3'd0;
      pos        <= 5'd0;
      div        <= '0;
      shift_byte <= '0;
      saved_reg  <= '0;
      saved_data <= '0;
      received   <= '0;
      nack       <= 1'b0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      res_valid  <= 1'b0;
    end else begin
      active     <= active_next;
      is_read    <= is_read_next;
      seg        <= seg_next;
      pos        <= pos_next;
      div        <= div_next;
      shift_byte <= shift_byte_next;
      saved_reg  <= saved_reg_next;
      saved_data <= saved_data_next;
      received   <= received_next;
      nack       <= nack_next;
      scl        <= scl_next;
      sda        <= sda_next;
      if (step) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.scl_out     <= scl_next;
      res.sda_out     <= sda_next;
      res.busy_res    <= busy;
      res.done_res    <= done;
      res.read_data   <= received_next;
      res.ack_missing <= nack_next;
    end
  end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Open-drain I2C master for single-register reads and writes.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the bus divider and yields exactly one
// output transaction with the SCL/SDA levels, busy, done, the last read byte
// and the sticky missing-acknowledge flag. The block sustains one item per
// clock while the output is not back-pressured; an item passes through the
// two-entry input queue and then the sequencer's output register on its way
// out. Commands are taken only while no bus transaction runs; a bus slot
// lasts half_period_ticks items (zero counts as one). Configuration
// registers are written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module i2c_register_access_master
  import i2cram_pkg::*;
#(
  parameter int DIVIDER_BITS = DIVIDER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cmd[1:0], reg_addr[9:2], write_data[17:10], sda_in[18], zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
  // ack_missing[12], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [HALF_W-1:0]      cfg_data
);

  logic [DEV_W-1:0]  device_address;
  logic [HALF_W-1:0] half_period_ticks;
  logic              q_valid;
  logic              q_ready;
  item_t             q_item;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= '0;
      half_period_ticks <= HALF_W'(250);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:    device_address    <= cfg_data[DEV_W-1:0];
        CFG_HALF_PERIOD_TICKS: half_period_ticks <= cfg_data;
        default:               ;
      endcase
    end
  end

  i2cram_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item)
  );

  i2cram_engine #(
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .device_address    (device_address),
    .half_period_ticks (half_period_ticks),
    .res_valid         (m_axis_tvalid),
    .res_ready         (m_axis_tready),
    .res               (res)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), res};

  // a transaction that ends must still be flagged busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[2])
    else $error("done without busy");

  // both lines released whenever no transaction runs
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[1:0] == 2'b11))
    else $error("lines driven while idle");

  // every item the sequencer takes shows up at the output
  a_step_out: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> m_axis_tvalid)
    else $error("item lost in sequencer");

endmodule
